### rtl/core/pyrt_pkg.sv
// Package for the paraxial y-nu ray trace block.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
package pyrt_pkg;
    typedef enum logic [2:0] {
        OP_MAC    = 3'b001,
        OP_NUM    = 3'b010,
        OP_DIV    = 3'b100
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic    sub;
    } alu_ctl_t;

    localparam logic [2:0] REG_START_HEIGHT     = 3'd0;
    localparam logic [2:0] REG_START_SLOPE      = 3'd1;
    localparam logic [2:0] REG_START_HEIGHT_BAR = 3'd2;
    localparam logic [2:0] REG_START_SLOPE_BAR  = 3'd3;
    localparam logic [2:0] REG_START_AT_FIRST   = 3'd4;
endpackage

### rtl/core/pyrt_alu.sv
// Shared arithmetic unit: multiply-accumulate with saturation, and a
// restoring divider one quotient bit per cycle. Uses pyrt_pkg.
`timescale 1ns / 1ps
module pyrt_alu #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pyrt_pkg::alu_ctl_t          ctl,
    input  logic signed [WORD_BITS-1:0] base,
    input  logic signed [WORD_BITS-1:0] op_a,
    input  logic signed [WORD_BITS-1:0] op_b,
    input  logic signed [WORD_BITS-1:0] op_c,
    input  logic signed [WORD_BITS-1:0] op_d,
    input  logic signed [WORD_BITS-1:0] divisor,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result,
    output logic                        sat
);
    localparam int PW = 2 * WORD_BITS;
    localparam int NW = PW + 1;
    localparam int CW = $clog2(NW + 1);
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_MUL2 = 4'b0010, S_DIV = 4'b0100, S_FIN = 4'b1000
    } st_t;
    st_t st_reg, st_next;

    logic signed [PW-1:0] prod_reg;
    logic signed [NW-1:0] num_reg;
    pyrt_pkg::alu_op_t    op_reg;
    logic                 sub_reg;
    logic [NW-1:0]        quo_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] dmag_reg;
    logic                 nneg_reg, dneg_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [WORD_BITS-1:0] base_reg;

    logic signed [PW-1:0] mul_out;
    logic signed [PW-1:0] sh;
    logic signed [PW+1:0] acc;
    logic signed [NW-1:0] num_now;
    logic [NW-1:0]        nmag;
    logic [WORD_BITS:0]   rem_sh;
    logic signed [NW:0]   q_s;

    assign mul_out = (st_reg == S_MUL2) ? op_c * op_d : op_a * op_b;
    assign sh  = prod_reg >>> FRACTION_BITS;
    assign acc = sub_reg ? (PW+2)'(base_reg) - (PW+2)'(sh) : (PW+2)'(base_reg) + (PW+2)'(sh);
    assign num_now = NW'(prod_reg) - NW'(mul_out);
    assign nmag = num_now[NW-1] ? NW'(-num_now) : num_now;
    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign q_s = (nneg_reg != dneg_reg) ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (ctl.start) st_next = (ctl.op == pyrt_pkg::OP_MAC) ? S_FIN : S_MUL2;
            S_MUL2: st_next = (op_reg == pyrt_pkg::OP_DIV) ? S_DIV : S_FIN;
            S_DIV:  if (cnt_reg == CW'(NW - 1)) st_next = S_FIN;
            S_FIN:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= S_IDLE;
        else st_reg <= st_next;
        case (st_reg)
            S_IDLE: begin
                prod_reg <= mul_out;
                base_reg <= base;
                op_reg   <= ctl.op;
                sub_reg  <= ctl.sub;
            end
            S_MUL2: begin
                num_reg  <= nmag;
                nneg_reg <= num_now[NW-1];
                dneg_reg <= divisor[WORD_BITS-1];
                dmag_reg <= divisor[WORD_BITS-1] ? WORD_BITS'(-divisor) : divisor;
                prod_reg <= PW'(num_now);
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            S_DIV: begin
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_sh >= {1'b0, dmag_reg}) begin
                    rem_reg <= WORD_BITS'(rem_sh - {1'b0, dmag_reg});
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[WORD_BITS-1:0];
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign done = (st_reg == S_FIN);

    always_comb begin
        result = '0;
        sat = 1'b0;
        if (op_reg == pyrt_pkg::OP_DIV) begin
            if (dmag_reg == '0) begin
                if (prod_reg != '0) begin
                    sat = 1'b1;
                    result = nneg_reg ? WMIN : WMAX;
                end
            end else if (q_s > (NW+1)'(WMAX)) begin
                sat = 1'b1; result = WMAX;
            end else if (q_s < (NW+1)'(WMIN)) begin
                sat = 1'b1; result = WMIN;
            end else result = q_s[WORD_BITS-1:0];
        end else begin
            if (acc > (PW+2)'(WMAX)) begin
                sat = 1'b1; result = WMAX;
            end else if (acc < (PW+2)'(WMIN)) begin
                sat = 1'b1; result = WMIN;
            end else result = acc[WORD_BITS-1:0];
        end
    end
endmodule

### rtl/core/paraxial_ynu_ray_trace.sv
// Top level of the paraxial y-nu ray trace; sequencer, state and ports. Uses pyrt_pkg, pyrt_alu.
// A refracting surface runs two divides of 2*WORD_BITS+1 steps each in the shared unit;
// first and pass-through surfaces skip them. Surfaces are taken one at a time:
// s_tready is high whenever the sequencer is idle, and a result still held at the
// output stalls the next surface at its store step.
// Reset (aresetn low, synchronous) restores the start registers, ray state and handshake.
`timescale 1ns / 1ps
module paraxial_ynu_ray_trace #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [WORD_BITS-1:0]   cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: gap_thickness, gap_infinite, curvature, surface_power, index_given,
    //        refr_index, dir_given, dir_negative, pass_through
    input  logic [((4*WORD_BITS+4+7)/8)*8-1:0] s_tdata,
    input  logic                   s_tuser,   // first_item
    input  logic                   s_tlast,   // last_item
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: ray_height, ray_slope, ray_incidence, chief_height, chief_slope,
    //        chief_incidence, saturated
    output logic [((6*WORD_BITS+1+7)/8)*8-1:0] m_tdata,
    output logic                   m_tlast    // final_result
);
    localparam int W = WORD_BITS;
    localparam int OW = ((6*W+1+7)/8)*8;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(1) << FRACTION_BITS;

    typedef enum logic [9:0] {
        P_IDLE = 10'b0000000001, P_H   = 10'b0000000010, P_HB  = 10'b0000000100,
        P_S    = 10'b0000001000, P_SB  = 10'b0000010000, P_A   = 10'b0000100000,
        P_AB   = 10'b0001000000, P_OUT = 10'b0010000000, P_WAIT = 10'b0100000000,
        P_ST   = 10'b1000000000
    } ph_t;
    ph_t ph_reg, ph_next;

    logic signed [W-1:0] sh_reg, ss_reg, shb_reg, ssb_reg;
    logic                safs_reg;
    logic signed [W-1:0] ah_reg, as_reg, ch_reg, cs_reg, nb_reg, pg_reg;
    logic                dirb_reg;
    logic signed [W-1:0] t_reg, cv_reg, pw_reg, na_reg;
    logic                first_reg, last_reg, inf_reg, pt_reg, dir_reg;
    logic signed [W-1:0] h_reg, hb_reg, s_reg, sb_reg, a_reg, ab_reg;
    logic                sat_reg, wait_reg;
    logic [OW-1:0]       out_reg;
    logic                outv_reg, outl_reg;

    logic signed [W-1:0] in_t, in_cv, in_pw;
    logic                in_inf, in_ig, in_dg, in_dn, in_pt;
    logic [W-2:0]        in_ri;
    logic [W-1:0]        old_mag, mag;
    logic                dir;
    logic                acc_in;

    pyrt_pkg::alu_ctl_t  ctl;
    logic signed [W-1:0] u_base, u_a, u_b, u_c, u_d, u_res;
    logic                u_done, u_sat;

    assign in_t   = s_tdata[W-1:0];
    assign in_inf = s_tdata[W];
    assign in_cv  = s_tdata[2*W:W+1];
    assign in_pw  = s_tdata[3*W:2*W+1];
    assign in_ig  = s_tdata[3*W+1];
    assign in_ri  = s_tdata[4*W:3*W+2];
    assign in_dg  = s_tdata[4*W+1];
    assign in_dn  = s_tdata[4*W+2];
    assign in_pt  = s_tdata[4*W+3];

    assign old_mag = nb_reg[W-1] ? W'(-nb_reg) : nb_reg;
    assign mag = in_ig ? {1'b0, in_ri} : old_mag;
    assign dir = in_dg ? in_dn : dirb_reg;

    assign s_tready = (ph_reg == P_IDLE);
    assign acc_in = s_tvalid && s_tready;

    pyrt_alu #(.WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_alu (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .base(u_base), .op_a(u_a),
        .op_b(u_b), .op_c(u_c), .op_d(u_d), .divisor(na_reg), .done(u_done),
        .result(u_res), .sat(u_sat)
    );

    // issue an operation on entry to each phase from P_H to P_AB
    always_comb begin
        ctl = '{start: wait_reg == 1'b0 && ph_reg != P_IDLE && ph_reg != P_OUT
                && ph_reg != P_ST && ph_reg != P_WAIT,
                op: pyrt_pkg::OP_MAC, sub: 1'b0};
        u_base = '0; u_a = '0; u_b = '0; u_c = '0; u_d = '0;
        case (ph_reg)
            P_H: begin
                u_base = first_reg ? sh_reg : ah_reg;
                u_a = first_reg ? t_reg : pg_reg;
                u_b = first_reg ? ss_reg : as_reg;
                ctl.sub = first_reg;
            end
            P_HB: begin
                u_base = first_reg ? shb_reg : ch_reg;
                u_a = first_reg ? t_reg : pg_reg;
                u_b = first_reg ? ssb_reg : cs_reg;
                ctl.sub = first_reg;
            end
            P_S: begin
                ctl.op = pyrt_pkg::OP_DIV;
                u_a = nb_reg; u_b = as_reg; u_c = h_reg; u_d = pw_reg;
            end
            P_SB: begin
                ctl.op = pyrt_pkg::OP_DIV;
                u_a = nb_reg; u_b = cs_reg; u_c = hb_reg; u_d = pw_reg;
            end
            P_A:  begin u_base = s_reg;  u_a = h_reg;  u_b = cv_reg; end
            P_AB: begin u_base = sb_reg; u_a = hb_reg; u_b = cv_reg; end
            default: ;
        endcase
    end

    always_comb begin
        ph_next = ph_reg;
        case (ph_reg)
            P_IDLE: if (acc_in) ph_next = P_H;
            P_H: if (u_done || (first_reg && (!safs_reg || inf_reg))) ph_next = P_HB;
            P_HB: if (u_done || (first_reg && (!safs_reg || inf_reg)))
                ph_next = (first_reg || pt_reg) ? P_A : P_S;
            P_S:  if (u_done) ph_next = P_SB;
            P_SB: if (u_done) ph_next = P_A;
            P_A:  if (u_done) ph_next = P_AB;
            P_AB: if (u_done) ph_next = P_ST;
            P_ST: if (!outv_reg) ph_next = P_OUT;
            P_OUT: ph_next = P_IDLE;
            default: ph_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= P_IDLE;
            wait_reg <= 1'b0;
            outv_reg <= 1'b0;
            sh_reg <= '0; ss_reg <= '0; shb_reg <= '0; ssb_reg <= '0;
            safs_reg <= 1'b1;
            ah_reg <= '0; as_reg <= '0; ch_reg <= '0; cs_reg <= '0;
            nb_reg <= ONE; dirb_reg <= 1'b0; pg_reg <= '0;
        end else begin
            ph_reg <= ph_next;
            wait_reg <= (ph_next == ph_reg) && ph_reg != P_IDLE;
            if (cfg_we) begin
                case (cfg_index)
                    pyrt_pkg::REG_START_HEIGHT:     sh_reg <= cfg_data;
                    pyrt_pkg::REG_START_SLOPE:      ss_reg <= cfg_data;
                    pyrt_pkg::REG_START_HEIGHT_BAR: shb_reg <= cfg_data;
                    pyrt_pkg::REG_START_SLOPE_BAR:  ssb_reg <= cfg_data;
                    pyrt_pkg::REG_START_AT_FIRST:   safs_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (acc_in) begin
                t_reg <= in_t; cv_reg <= in_cv; pw_reg <= in_pw;
                first_reg <= s_tuser; last_reg <= s_tlast; inf_reg <= in_inf;
                pt_reg <= in_pt; dir_reg <= dir;
                na_reg <= dir ? W'(-mag) : mag;
                sat_reg <= 1'b0;
            end
            case (ph_reg)
                P_H: if (first_reg && !safs_reg) h_reg <= sh_reg;
                    else if (first_reg && inf_reg) begin
                        h_reg <= '0; sat_reg <= 1'b1;
                    end else if (u_done) begin
                        h_reg <= u_res; sat_reg <= sat_reg | u_sat;
                    end
                P_HB: begin
                    if (first_reg && !safs_reg) hb_reg <= shb_reg;
                    else if (first_reg && inf_reg) hb_reg <= WMIN;
                    else if (u_done) begin
                        hb_reg <= u_res; sat_reg <= sat_reg | u_sat;
                    end
                    if (first_reg) begin
                        s_reg <= ss_reg; sb_reg <= ssb_reg;
                    end else begin
                        s_reg <= as_reg; sb_reg <= cs_reg;
                    end
                end
                P_S:  if (u_done) begin s_reg <= u_res;  sat_reg <= sat_reg | u_sat; end
                P_SB: if (u_done) begin sb_reg <= u_res; sat_reg <= sat_reg | u_sat; end
                P_A:  if (u_done) begin a_reg <= u_res;  sat_reg <= sat_reg | u_sat; end
                P_AB: if (u_done) begin ab_reg <= u_res; sat_reg <= sat_reg | u_sat; end
                P_ST: if (!outv_reg) begin
                    ah_reg <= h_reg; as_reg <= s_reg; ch_reg <= hb_reg; cs_reg <= sb_reg;
                    pg_reg <= inf_reg ? WMAX : t_reg;
                    if (first_reg || !pt_reg) begin
                        nb_reg <= na_reg; dirb_reg <= dir_reg;
                    end
                    out_reg <= OW'({sat_reg, ab_reg, sb_reg, hb_reg, a_reg, s_reg, h_reg});
                    outl_reg <= last_reg;
                    outv_reg <= 1'b1;
                end
                default: ;
            endcase
            if (m_tvalid && m_tready) outv_reg <= 1'b0;
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = outl_reg;
endmodule

### rtl/core/pyrt_checker.sv
// Port-level checks for paraxial_ynu_ray_trace, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module pyrt_checker #(
    parameter int WORD_BITS = 32
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((6*WORD_BITS+1+7)/8)*8-1:0] m_tdata,
    input logic m_tlast
);
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after transfer");
    a_gap_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid) else $error("result repeated");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while waiting");
endmodule

bind paraxial_ynu_ray_trace pyrt_checker #(.WORD_BITS(WORD_BITS)) u_pyrt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

### bench/tb_paraxial_ynu_ray_trace.sv
// Testbench for paraxial_ynu_ray_trace: random and directed surface streams,
// checked against an in-bench y-nu trace predictor. Depends on pyrt_pkg.
`timescale 1ns / 1ps
module tb_paraxial_ynu_ray_trace;

    typedef struct {
        bit first, last, inf, ig, dg, dn, pt;
        logic signed [31:0] gap, curv, pwr;
        logic [30:0] ri;
    } surf_t;

    typedef struct {
        logic signed [31:0] h, s, a, hb, sb, ab;
        bit fin, sat;
    } trace_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_tvalid = 0, s_tuser = 0, s_tlast = 0, s_tready;
    logic [135:0] s_tdata = '0;
    logic m_tvalid, m_tlast, m_tready = 0;
    logic [199:0] m_tdata;

    paraxial_ynu_ray_trace dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // predictor state and registers
    logic signed [31:0] st_h, st_s, st_hb, st_sb, ax_h, ax_s, ch_h, ch_s, idx_prev, prev_gap;
    bit at_first, dir_before, clip;
    localparam logic signed [31:0] WMAX = 32'sh7fffffff, WMIN = 32'sh80000000;

    surf_t pending[$];
    surf_t cur;
    trace_t expected_traces[$];
    int errors = 0;
    bit quiet_sender = 0, long_hold_req = 0, hold_done = 0;
    int hold_cnt = 0;

    function automatic logic signed [31:0] clip_word(logic signed [127:0] v);
        if (v > 128'sd2147483647) begin clip = 1; return WMAX; end
        if (v < -128'sd2147483648) begin clip = 1; return WMIN; end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mac(logic signed [31:0] base, a, b, bit sub);
        logic signed [127:0] p;
        p = $signed(a) * $signed(b);
        p = p >>> 16;
        if (sub) p = -p;
        return clip_word(p + base);
    endfunction

    function automatic logic signed [31:0] fx_refract(logic signed [31:0] nb, sl, h, pw, na);
        logic signed [127:0] num, dd;
        num = $signed(nb) * $signed(sl);
        num = num - $signed(h) * $signed(pw);
        if (na == 0) begin
            if (num == 0) return 0;
            clip = 1;
            return num < 0 ? WMIN : WMAX;
        end
        dd = na;
        return clip_word(num / dd);
    endfunction

    function automatic trace_t trace_surface(surf_t x);
        trace_t r;
        logic signed [31:0] mag, na;
        bit dir;
        mag = idx_prev < 0 ? -idx_prev : idx_prev;
        if (x.ig) mag = {1'b0, x.ri};
        dir = x.dg ? x.dn : dir_before;
        clip = 0;
        if (x.first) begin
            idx_prev = dir ? -mag : mag;
            dir_before = dir;
            r.s = st_s; r.sb = st_sb;
            if (!at_first) begin
                r.h = st_h; r.hb = st_hb;
            end else if (x.inf) begin
                r.h = 0; r.hb = WMIN; clip = 1;
            end else begin
                r.h = fx_mac(st_h, x.gap, st_s, 1);
                r.hb = fx_mac(st_hb, x.gap, st_sb, 1);
            end
        end else begin
            r.h = fx_mac(ax_h, prev_gap, ax_s, 0);
            r.hb = fx_mac(ch_h, prev_gap, ch_s, 0);
            if (x.pt) begin
                r.s = ax_s; r.sb = ch_s;
            end else begin
                na = dir ? -mag : mag;
                r.s = fx_refract(idx_prev, ax_s, r.h, x.pwr, na);
                r.sb = fx_refract(idx_prev, ch_s, r.hb, x.pwr, na);
                idx_prev = na;
                dir_before = dir;
            end
        end
        r.a = fx_mac(r.s, r.h, x.curv, 0);
        r.ab = fx_mac(r.sb, r.hb, x.curv, 0);
        ax_h = r.h; ax_s = r.s; ch_h = r.hb; ch_s = r.sb;
        prev_gap = x.inf ? WMAX : x.gap;
        r.fin = x.last;
        r.sat = clip;
        return r;
    endfunction

    task automatic queue_surf(surf_t x);
        pending.insert(pending.size(), x);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_traces.insert(expected_traces.size(), trace_surface(cur));
            if (!(s_tvalid && !s_tready)) begin
                if (pending.size() > 0 && (quiet_sender || $urandom_range(99) >= 29)) begin
                    cur = pending.pop_front();
                    s_tvalid <= 1;
                    s_tuser <= cur.first;
                    s_tlast <= cur.last;
                    s_tdata <= {4'b0, cur.pt, cur.dn, cur.dg, cur.ri, cur.ig, cur.pwr,
                                cur.curv, cur.inf, cur.gap};
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (long_hold_req && !hold_done && hold_cnt == 0) begin
            hold_cnt <= 600;
            hold_done <= 1;
            m_tready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 0;
        end else begin
            m_tready <= quiet_sender || $urandom_range(99) >= 29;
        end
    end

    // monitor
    always @(posedge aclk) begin
        trace_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_traces.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = expected_traces.pop_front();
                if (m_tdata[31:0] !== e.h) begin
                    $error("ray_height exp %h got %h", e.h, m_tdata[31:0]); errors++;
                end
                if (m_tdata[63:32] !== e.s) begin
                    $error("ray_slope exp %h got %h", e.s, m_tdata[63:32]); errors++;
                end
                if (m_tdata[95:64] !== e.a) begin
                    $error("ray_incidence exp %h got %h", e.a, m_tdata[95:64]); errors++;
                end
                if (m_tdata[127:96] !== e.hb) begin
                    $error("chief_height exp %h got %h", e.hb, m_tdata[127:96]); errors++;
                end
                if (m_tdata[159:128] !== e.sb) begin
                    $error("chief_slope exp %h got %h", e.sb, m_tdata[159:128]); errors++;
                end
                if (m_tdata[191:160] !== e.ab) begin
                    $error("chief_incidence exp %h got %h", e.ab, m_tdata[191:160]); errors++;
                end
                if (m_tdata[192] !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, m_tdata[192]); errors++;
                end
                if (m_tlast !== e.fin) begin
                    $error("final_result exp %b got %b", e.fin, m_tlast); errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] small_q(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic surf_t rand_surf(bit first, bit last);
        surf_t x;
        x.first = first; x.last = last;
        if ($urandom_range(99) < 8) begin
            x.gap = $urandom; x.curv = $urandom; x.pwr = $urandom; x.ri = 31'($urandom);
        end else begin
            x.gap = $urandom_range(9) == 0 ? small_q(20 << 16) : $urandom_range(0, 20 << 16);
            x.curv = small_q(13107);
            x.pwr = small_q(13107);
            x.ri = 31'($urandom_range(65536, 131072));
        end
        if ($urandom_range(49) == 0) x.ri = 0;
        x.inf = $urandom_range(19) == 0;
        x.ig = $urandom_range(3) != 0;
        x.dg = $urandom_range(3) == 0;
        x.dn = 1'($urandom_range(1));
        x.pt = $urandom_range(9) == 0;
        return x;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            pyrt_pkg::REG_START_HEIGHT:     st_h = v;
            pyrt_pkg::REG_START_SLOPE:      st_s = v;
            pyrt_pkg::REG_START_HEIGHT_BAR: st_hb = v;
            pyrt_pkg::REG_START_SLOPE_BAR:  st_sb = v;
            pyrt_pkg::REG_START_AT_FIRST:   at_first = v[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending.size() > 0 || s_tvalid || expected_traces.size() > 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic push_paths(int n);
        int len;
        repeat (n) begin
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(2, 8);
                for (int k = 0; k < len; k++) queue_surf(rand_surf(k == 0, k == len - 1));
            end else begin
                queue_surf(rand_surf(1'($urandom_range(1)), 1'($urandom_range(1))));
            end
        end
    endtask

    initial begin
        surf_t d;
        st_h = 0; st_s = 0; st_hb = 0; st_sb = 0; at_first = 1;
        ax_h = 0; ax_s = 0; ch_h = 0; ch_s = 0;
        idx_prev = 32'sh10000; dir_before = 0; prev_gap = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        write_reg(pyrt_pkg::REG_START_HEIGHT, 32'h0001_0000);
        write_reg(pyrt_pkg::REG_START_SLOPE, 32'hfffe_0000);
        write_reg(pyrt_pkg::REG_START_HEIGHT_BAR, 32'h0000_8000);
        write_reg(pyrt_pkg::REG_START_SLOPE_BAR, 32'h0000_4000);
        write_reg(pyrt_pkg::REG_START_AT_FIRST, 32'd1);

        // directed surfaces
        @(negedge aclk);
        d = rand_surf(1, 0); d.inf = 0; d.gap = 32'h0005_0000; d.ig = 1; d.ri = 31'h10000;
        d.dg = 1; d.dn = 0; d.pt = 0; queue_surf(d);
        d = rand_surf(0, 0); d.pt = 0; d.ig = 1; d.ri = 31'h18000; d.dg = 0; d.inf = 0;
        queue_surf(d);
        d.pt = 1; d.gap = WMAX; queue_surf(d);
        d.pt = 0; d.gap = WMIN; d.curv = WMAX; d.pwr = WMIN; queue_surf(d);
        d.gap = 32'h0002_0000; d.curv = WMIN; d.pwr = WMAX; d.ri = 0; queue_surf(d);
        d.ri = 31'h7fffffff; d.dg = 1; d.dn = 1; queue_surf(d);
        d.ig = 0; d.dg = 1; d.dn = 0; queue_surf(d);
        d.inf = 1; d.last = 1; queue_surf(d);
        d = rand_surf(0, 0); d.pt = 0; d.inf = 0; queue_surf(d);
        d = rand_surf(1, 1); d.inf = 1; queue_surf(d);
        d = rand_surf(1, 0); d.inf = 0; d.ig = 0; d.dg = 0; d.gap = WMIN; queue_surf(d);
        d = rand_surf(0, 1); d.ig = 1; d.ri = 0; d.pt = 0; d.pwr = 0; d.curv = 0;
        queue_surf(d);
        for (int k = 0; k < 6; k++) queue_surf(rand_surf(k == 0, k == 5));
        drain();

        write_reg(pyrt_pkg::REG_START_AT_FIRST, 32'd0);
        write_reg(pyrt_pkg::REG_START_HEIGHT, WMAX);
        write_reg(pyrt_pkg::REG_START_HEIGHT_BAR, WMIN);
        @(negedge aclk);
        d = rand_surf(1, 0); d.inf = 1; queue_surf(d);
        d = rand_surf(0, 1); queue_surf(d);
        d = rand_surf(1, 1); d.inf = 0; queue_surf(d);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(pyrt_pkg::REG_START_HEIGHT, ph == 2 ? WMIN : small_q(5 << 16));
            write_reg(pyrt_pkg::REG_START_SLOPE,
                      ph == 2 ? WMAX : (ph == 4 ? $urandom : small_q(1 << 14)));
            write_reg(pyrt_pkg::REG_START_HEIGHT_BAR, ph == 2 ? WMAX : small_q(3 << 16));
            write_reg(pyrt_pkg::REG_START_SLOPE_BAR,
                      ph == 2 ? WMIN : (ph == 4 ? $urandom : small_q(1 << 14)));
            write_reg(pyrt_pkg::REG_START_AT_FIRST, 32'(ph % 3 != 1));
            @(negedge aclk);
            quiet_sender = (ph == 3);
            if (ph == 5) long_hold_req = 1;
            push_paths(39);
            drain();
        end

        @(negedge aclk);
        while (pending.size() > 0 || s_tvalid || expected_traces.size() > 0) @(negedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
